FILE: design/assert_macros.svh
// Assertion macros shared by the RTL of the two-level cache core.
// Depends on nothing; a module that asserts must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TLWBC_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define TLWBC_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: design/tlwbc_pkg.sv
// Package of the two-level write-back cache core: geometry, codes, state type.
// Used by the top level and the testbench; depends on nothing.
`default_nettype none

package tlwbc_pkg;

  localparam int WORD_W    = 32;
  localparam int COST_W    = 12;
  localparam int CFG_W     = 8;
  localparam int OFF_W     = 4;   // word within a 64-byte line
  localparam int WPL       = 16;
  localparam int L1_IDX_W  = 8;
  localparam int L1_TAG_W  = 6;
  localparam int L2_IDX_W  = 9;
  localparam int L2_TAG_W  = 5;
  localparam int BLK_W     = 14;  // block number within main memory
  localparam int MAIN_AW   = 18;
  localparam int L1_LINES  = 256;
  localparam int L2_LINES  = 512;
  localparam int MAIN_WORDS = 262144;
  localparam int L1M_W     = L1_TAG_W + 2;
  localparam int L2M_W     = L2_TAG_W + 2;

  // Highest word-aligned byte address inside main memory; anything above it is out of range.
  localparam logic [31:0] ADDR_LIMIT = 32'h000F_FFFC;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [2:0] REG_L1_READ   = 3'd0;
  localparam logic [2:0] REG_L1_WRITE  = 3'd1;
  localparam logic [2:0] REG_L2_READ   = 3'd2;
  localparam logic [2:0] REG_L2_WRITE  = 3'd3;
  localparam logic [2:0] REG_MEM_READ  = 3'd4;
  localparam logic [2:0] REG_MEM_WRITE = 3'd5;

  localparam logic [7:0] RST_L1_READ   = 8'd1;
  localparam logic [7:0] RST_L1_WRITE  = 8'd1;
  localparam logic [7:0] RST_L2_READ   = 8'd10;
  localparam logic [7:0] RST_L2_WRITE  = 8'd10;
  localparam logic [7:0] RST_MEM_READ  = 8'd100;
  localparam logic [7:0] RST_MEM_WRITE = 8'd50;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_L1_RD,
    ST_L1_CHK,
    ST_L2_RD,
    ST_L2_CHK,
    ST_CP_L2MEM,
    ST_CP_MEML2,
    ST_CP_L2F,
    ST_CP_L1L2,
    ST_CP_FL1,
    ST_WORD,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

FILE: design/tlwbc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; every memory of the cache core is one of these.
`default_nettype none

module tlwbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/two_level_writeback_cache_core.sv
// Top level of the two-level direct-mapped write-back cache with a time counter.
// Depends on tlwbc_pkg, tlwbc_ram and assert_macros.svh.
//
// Usage:
// Input transactions (opcode, byte_address, write_data) enter on in_valid and
// in_stall; one result transaction (read_data, access_cost, elapsed_time,
// out_of_range) leaves per input on out_valid and out_stall. Cost registers
// are written through cfg_write, cfg_index and cfg_data; the user must write
// them only while the core idles (not enforced). One item is worked on at a
// time. The state lives in five RAMs: L1 and L2 tag/valid/dirty arrays, L1
// and L2 line data, and main memory, all with registered read data. A clear,
// a no-op or an out-of-range access skips the caches. Every line moved
// between levels goes through the one copy counter, so a miss takes longer
// the more block copies it needs (fill, dirty victims at each level). After
// reset the core sweeps main memory and the tag arrays to zero with in_stall
// high; configuration writes are taken anyway. A finished result sits in the
// output register while the next item is accepted; if the receiver stalls,
// the following result waits in the core.
`default_nettype none
`include "assert_macros.svh"

module two_level_writeback_cache_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] byte_address,
  input  wire logic [31:0] write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      read_data,
  output logic [11:0]      access_cost,
  output logic [31:0]      elapsed_time,
  output logic             out_of_range,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  tlwbc_pkg::state_t state, state_next;

  logic [7:0] l1_read_cost, l1_write_cost, l2_read_cost, l2_write_cost;
  logic [7:0] memory_read_cost, memory_write_cost;

  logic [1:0]  op_q;
  logic [31:0] addr_q;
  logic [31:0] wdata_q;
  logic        oor_q;
  logic        do_read;
  logic [11:0] cost;
  logic        phase_vict;
  logic        v1_dirty;
  logic [5:0]  v1_tag;
  logic [4:0]  v2_tag;
  logic [4:0]  cnt;
  logic [17:0] clr;
  logic [31:0] fbuf [tlwbc_pkg::WPL];
  logic [31:0] frd;
  logic [31:0] elapsed;

  // RAM ports
  logic        l1d_we, l1m_we, l2d_we, l2m_we, mem_we;
  logic [11:0] l1d_waddr, l1d_raddr;
  logic [12:0] l2d_waddr, l2d_raddr;
  logic [7:0]  l1m_waddr;
  logic [8:0]  l2m_waddr;
  logic [17:0] mem_waddr, mem_raddr;
  logic [31:0] l1d_wdata, l1d_rdata, l2d_wdata, l2d_rdata, mem_wdata, mem_rdata;
  logic [7:0]  l1m_wdata, l1m_rdata;
  logic [6:0]  l2m_wdata, l2m_rdata;

  logic [7:0]  idx1;
  logic [5:0]  tag1;
  logic [3:0]  off;
  logic [13:0] bnum;
  logic [8:0]  idx2;
  logic [4:0]  tag2;
  logic [3:0]  cnt_m1;
  logic        cp_last;
  logic        cp_wr;
  logic        l1_hit, l2_hit, l2_vict;
  logic        in_accept, in_oor, out_load;

  assign idx1    = addr_q[13:6];
  assign tag1    = addr_q[19:14];
  assign off     = addr_q[5:2];
  assign bnum    = phase_vict ? {v1_tag, idx1} : addr_q[19:6];
  assign idx2    = bnum[8:0];
  assign tag2    = bnum[13:9];
  assign cnt_m1  = cnt[3:0] - 4'd1;
  assign cp_last = (cnt == 5'd16);
  assign cp_wr   = (cnt != 5'd0);

  assign l1_hit  = l1m_rdata[7] && (l1m_rdata[5:0] == tag1);
  assign l2_hit  = l2m_rdata[6] && (l2m_rdata[4:0] == tag2);
  assign l2_vict = !l2_hit && l2m_rdata[6] && l2m_rdata[5];

  assign in_stall  = (state != tlwbc_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_oor    = (byte_address > tlwbc_pkg::ADDR_LIMIT);
  assign out_load  = (state == tlwbc_pkg::ST_FINISH) && (!out_valid || !out_stall);

  tlwbc_ram #(.WIDTH(tlwbc_pkg::WORD_W), .DEPTH(tlwbc_pkg::L1_LINES * tlwbc_pkg::WPL)) u_l1d (
    .clk(clk), .we(l1d_we), .waddr(l1d_waddr), .wdata(l1d_wdata),
    .raddr(l1d_raddr), .rdata(l1d_rdata)
  );
  tlwbc_ram #(.WIDTH(tlwbc_pkg::L1M_W), .DEPTH(tlwbc_pkg::L1_LINES)) u_l1m (
    .clk(clk), .we(l1m_we), .waddr(l1m_waddr), .wdata(l1m_wdata),
    .raddr(idx1), .rdata(l1m_rdata)
  );
  tlwbc_ram #(.WIDTH(tlwbc_pkg::WORD_W), .DEPTH(tlwbc_pkg::L2_LINES * tlwbc_pkg::WPL)) u_l2d (
    .clk(clk), .we(l2d_we), .waddr(l2d_waddr), .wdata(l2d_wdata),
    .raddr(l2d_raddr), .rdata(l2d_rdata)
  );
  tlwbc_ram #(.WIDTH(tlwbc_pkg::L2M_W), .DEPTH(tlwbc_pkg::L2_LINES)) u_l2m (
    .clk(clk), .we(l2m_we), .waddr(l2m_waddr), .wdata(l2m_wdata),
    .raddr(idx2), .rdata(l2m_rdata)
  );
  tlwbc_ram #(.WIDTH(tlwbc_pkg::WORD_W), .DEPTH(tlwbc_pkg::MAIN_WORDS)) u_main (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tlwbc_pkg::ST_CLEAR: begin
        if (clr == 18'h3FFFF) state_next = tlwbc_pkg::ST_IDLE;
      end
      tlwbc_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (opcode == tlwbc_pkg::OP_CLEAR || opcode == tlwbc_pkg::OP_NOP || in_oor) begin
            state_next = tlwbc_pkg::ST_FINISH;
          end else begin
            state_next = tlwbc_pkg::ST_L1_RD;
          end
        end
      end
      tlwbc_pkg::ST_L1_RD: state_next = tlwbc_pkg::ST_L1_CHK;
      tlwbc_pkg::ST_L1_CHK: begin
        state_next = l1_hit ? tlwbc_pkg::ST_WORD : tlwbc_pkg::ST_L2_RD;
      end
      tlwbc_pkg::ST_L2_RD: state_next = tlwbc_pkg::ST_L2_CHK;
      tlwbc_pkg::ST_L2_CHK: begin
        priority if (l2_vict) state_next = tlwbc_pkg::ST_CP_L2MEM;
        else if (phase_vict)  state_next = tlwbc_pkg::ST_CP_L1L2;
        else if (l2_hit)      state_next = tlwbc_pkg::ST_CP_L2F;
        else                  state_next = tlwbc_pkg::ST_CP_MEML2;
      end
      tlwbc_pkg::ST_CP_L2MEM: begin
        if (cp_last) begin
          state_next = phase_vict ? tlwbc_pkg::ST_CP_L1L2 : tlwbc_pkg::ST_CP_MEML2;
        end
      end
      tlwbc_pkg::ST_CP_MEML2, tlwbc_pkg::ST_CP_L2F: begin
        if (cp_last) begin
          state_next = v1_dirty ? tlwbc_pkg::ST_L2_RD : tlwbc_pkg::ST_CP_FL1;
        end
      end
      tlwbc_pkg::ST_CP_L1L2: begin
        if (cp_last) state_next = tlwbc_pkg::ST_CP_FL1;
      end
      tlwbc_pkg::ST_CP_FL1: begin
        if (cp_last) state_next = tlwbc_pkg::ST_WORD;
      end
      tlwbc_pkg::ST_WORD: state_next = tlwbc_pkg::ST_FINISH;
      tlwbc_pkg::ST_FINISH: begin
        if (out_load) state_next = tlwbc_pkg::ST_IDLE;
      end
      default: state_next = tlwbc_pkg::ST_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    l1d_we = 1'b0; l1d_waddr = {idx1, off}; l1d_wdata = wdata_q;
    l1d_raddr = {idx1, off};
    l1m_we = 1'b0; l1m_waddr = idx1; l1m_wdata = {2'b11, tag1};
    l2d_we = 1'b0; l2d_waddr = {idx2, cnt_m1}; l2d_wdata = mem_rdata;
    l2d_raddr = {idx2, cnt[3:0]};
    l2m_we = 1'b0; l2m_waddr = idx2; l2m_wdata = {2'b10, tag2};
    mem_we = 1'b0; mem_waddr = {v2_tag, idx2, cnt_m1}; mem_wdata = l2d_rdata;
    mem_raddr = {bnum, cnt[3:0]};
    unique case (state)
      tlwbc_pkg::ST_CLEAR: begin
        l1m_we = 1'b1; l1m_waddr = clr[7:0]; l1m_wdata = '0;
        l2m_we = 1'b1; l2m_waddr = clr[8:0]; l2m_wdata = '0;
        mem_we = 1'b1; mem_waddr = clr;      mem_wdata = '0;
      end
      tlwbc_pkg::ST_CP_L2MEM: begin
        mem_we = cp_wr;
      end
      tlwbc_pkg::ST_CP_MEML2: begin
        l2d_we = cp_wr;
        l2m_we = cp_last;
      end
      tlwbc_pkg::ST_CP_L1L2: begin
        l1d_raddr = {idx1, cnt[3:0]};
        l2d_we    = cp_wr;
        l2d_wdata = l1d_rdata;
        l2m_we    = cp_last;
        l2m_wdata = {2'b11, tag2};
      end
      tlwbc_pkg::ST_CP_FL1: begin
        l1d_we    = cp_wr;
        l1d_waddr = {idx1, cnt_m1};
        l1d_wdata = frd;
        l1m_we    = cp_last;
        l1m_wdata = {2'b10, tag1};
      end
      tlwbc_pkg::ST_WORD: begin
        l1d_we = (op_q == tlwbc_pkg::OP_WRITE);
        l1m_we = (op_q == tlwbc_pkg::OP_WRITE);
      end
      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      l1_read_cost      <= tlwbc_pkg::RST_L1_READ;
      l1_write_cost     <= tlwbc_pkg::RST_L1_WRITE;
      l2_read_cost      <= tlwbc_pkg::RST_L2_READ;
      l2_write_cost     <= tlwbc_pkg::RST_L2_WRITE;
      memory_read_cost  <= tlwbc_pkg::RST_MEM_READ;
      memory_write_cost <= tlwbc_pkg::RST_MEM_WRITE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tlwbc_pkg::REG_L1_READ:   l1_read_cost      <= cfg_data;
        tlwbc_pkg::REG_L1_WRITE:  l1_write_cost     <= cfg_data;
        tlwbc_pkg::REG_L2_READ:   l2_read_cost      <= cfg_data;
        tlwbc_pkg::REG_L2_WRITE:  l2_write_cost     <= cfg_data;
        tlwbc_pkg::REG_MEM_READ:  memory_read_cost  <= cfg_data;
        tlwbc_pkg::REG_MEM_WRITE: memory_write_cost <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tlwbc_pkg::ST_CLEAR;
      clr       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
      elapsed   <= '0;
    end else begin
      state <= state_next;
      if (state == tlwbc_pkg::ST_CLEAR) clr <= clr + 18'd1;
      if (state == tlwbc_pkg::ST_CP_L2MEM || state == tlwbc_pkg::ST_CP_MEML2 ||
          state == tlwbc_pkg::ST_CP_L2F || state == tlwbc_pkg::ST_CP_L1L2 ||
          state == tlwbc_pkg::ST_CP_FL1) begin
        cnt <= cp_last ? 5'd0 : cnt + 5'd1;
      end else begin
        cnt <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        elapsed   <= (op_q == tlwbc_pkg::OP_CLEAR) ? 32'd0 : elapsed + {20'd0, cost};
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item payload and datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q       <= opcode;
      addr_q     <= byte_address;
      wdata_q    <= write_data;
      oor_q      <= in_oor && (opcode == tlwbc_pkg::OP_READ || opcode == tlwbc_pkg::OP_WRITE);
      do_read    <= !in_oor && (opcode == tlwbc_pkg::OP_READ);
      cost       <= '0;
      phase_vict <= 1'b0;
    end
    if (state == tlwbc_pkg::ST_L1_CHK) begin
      v1_dirty <= l1m_rdata[7] && l1m_rdata[6];
      v1_tag   <= l1m_rdata[5:0];
    end
    if (state == tlwbc_pkg::ST_L2_CHK) begin
      v2_tag <= l2m_rdata[4:0];
      cost   <= cost + (l2_hit ? 12'd0 : {4'd0, memory_read_cost})
                     + (l2_vict ? {4'd0, memory_write_cost} : 12'd0)
                     + (phase_vict ? {4'd0, l2_write_cost} : {4'd0, l2_read_cost});
    end
    // After the fill is buffered, the dirty L1 victim goes to L2 next.
    if ((state == tlwbc_pkg::ST_CP_MEML2 || state == tlwbc_pkg::ST_CP_L2F) && cp_last) begin
      phase_vict <= v1_dirty;
    end
    if (state == tlwbc_pkg::ST_WORD) begin
      cost <= cost + ((op_q == tlwbc_pkg::OP_WRITE) ? {4'd0, l1_write_cost}
                                                     : {4'd0, l1_read_cost});
    end
    if (cp_wr && state == tlwbc_pkg::ST_CP_MEML2) fbuf[cnt_m1] <= mem_rdata;
    if (cp_wr && state == tlwbc_pkg::ST_CP_L2F)   fbuf[cnt_m1] <= l2d_rdata;
    frd <= fbuf[cnt[3:0]];
    if (out_load) begin
      read_data    <= do_read ? l1d_rdata : 32'd0;
      access_cost  <= cost;
      elapsed_time <= (op_q == tlwbc_pkg::OP_CLEAR) ? 32'd0 : elapsed + {20'd0, cost};
      out_of_range <= oor_q;
    end
  end

  `TLWBC_ASSERT_NEXT(a_accept_leaves_idle, in_accept, state != tlwbc_pkg::ST_IDLE)
  `TLWBC_ASSERT_NEXT(a_l1_hit_to_word, state == tlwbc_pkg::ST_L1_CHK && l1_hit,
                     state == tlwbc_pkg::ST_WORD)
  `TLWBC_ASSERT_IMP(a_copy_count_bound, 1'b1, cnt <= 5'd16)
  `TLWBC_ASSERT_NEXT(a_clear_zeroes_time, out_load && op_q == tlwbc_pkg::OP_CLEAR,
                     elapsed == 32'd0 && out_valid)

endmodule

`default_nettype wire

FILE: verif/two_level_writeback_cache_core_tb.sv
// Self-checking testbench of the two-level write-back cache core: a queue-fed driver,
// a monitor and an access-level predictor of both cache levels and main memory.
// Depends on tlwbc_pkg and the two_level_writeback_cache_core RTL.
`default_nettype none

module two_level_writeback_cache_core_tb;
  import tlwbc_pkg::*;

  localparam int QUIET_CYCLES = 120;
  localparam int TAIL_CYCLES  = 200;
  localparam int LIMIT_CYCLES = 4000000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int RAND_ITEMS   = 600;

  typedef enum logic [1:0] {K_ITEM, K_CFG, K_PHASE} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] data;
    logic [2:0]  reg_idx;
    logic [7:0]  reg_val;
    int          send_pct;
    int          recv_pct;
  } step_t;

  typedef struct {
    logic [31:0] rd;
    logic [11:0] cost;
    logic [31:0] elapsed;
    logic        oor;
  } access_result_t;

  typedef logic [31:0] block_t [WPL];

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] opcode = OP_NOP;
  logic [31:0] byte_address = 0;
  logic [31:0] write_data = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [31:0] read_data;
  logic [11:0] access_cost;
  logic [31:0] elapsed_time;
  logic out_of_range;
  logic cfg_write = 0;
  logic [2:0] cfg_index = REG_L1_READ;
  logic [7:0] cfg_data = 0;

  two_level_writeback_cache_core DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Predictor state.
  logic [7:0] cost_reg [6];
  logic [L1_TAG_W-1:0] l1_tag [L1_LINES];
  logic l1_vld [L1_LINES];
  logic l1_drt [L1_LINES];
  logic [31:0] l1_data [L1_LINES*WPL];
  logic [L2_TAG_W-1:0] l2_tag [L2_LINES];
  logic l2_vld [L2_LINES];
  logic l2_drt [L2_LINES];
  logic [31:0] l2_data [L2_LINES*WPL];
  logic [31:0] main_mem [int];
  logic [31:0] elapsed_acc;

  step_t stim_q [$];
  access_result_t pending_results [$];
  step_t cur_item, head;
  int send_pct = 0, recv_pct = 0;
  int quiet = 0;
  int mismatches = 0, results_seen = 0, items_sent = 0, hold_cnt = 0;
  bit hold_done = 0;
  logic nv, cw, took;
  longint cycles = 0;

  function automatic logic [31:0] main_word(int w);
    return main_mem.exists(w) ? main_mem[w] : 32'h0;
  endfunction

  function automatic int l2_block(logic [31:0] addr, bit is_wr, inout block_t blk);
    int idx = addr[14:6];
    logic [L2_TAG_W-1:0] tg = addr[19:15];
    int cost = 0;
    int vbase;
    if (!(l2_vld[idx] && l2_tag[idx] == tg)) begin
      block_t fill;
      for (int k = 0; k < WPL; k++) fill[k] = main_word({addr[19:6], 4'(k)});
      cost += cost_reg[REG_MEM_READ];
      if (l2_vld[idx] && l2_drt[idx]) begin
        vbase = {l2_tag[idx], 9'(idx), 4'd0};
        for (int k = 0; k < WPL; k++) main_mem[vbase + k] = l2_data[idx*WPL + k];
        cost += cost_reg[REG_MEM_WRITE];
      end
      for (int k = 0; k < WPL; k++) l2_data[idx*WPL + k] = fill[k];
      l2_vld[idx] = 1;
      l2_drt[idx] = 0;
      l2_tag[idx] = tg;
    end
    if (is_wr) begin
      for (int k = 0; k < WPL; k++) l2_data[idx*WPL + k] = blk[k];
      l2_drt[idx] = 1;
      cost += cost_reg[REG_L2_WRITE];
    end else begin
      for (int k = 0; k < WPL; k++) blk[k] = l2_data[idx*WPL + k];
      cost += cost_reg[REG_L2_READ];
    end
    return cost;
  endfunction

  function automatic int l1_access(logic [31:0] addr, bit is_wr, inout logic [31:0] word);
    int idx = addr[13:6];
    logic [L1_TAG_W-1:0] tg = addr[19:14];
    int off = addr[5:2];
    int cost = 0;
    block_t fill, victim;
    if (!(l1_vld[idx] && l1_tag[idx] == tg)) begin
      cost += l2_block({addr[31:6], 6'd0}, 0, fill);
      if (l1_vld[idx] && l1_drt[idx]) begin
        for (int k = 0; k < WPL; k++) victim[k] = l1_data[idx*WPL + k];
        cost += l2_block({12'd0, l1_tag[idx], 8'(idx), 6'd0}, 1, victim);
      end
      for (int k = 0; k < WPL; k++) l1_data[idx*WPL + k] = fill[k];
      l1_vld[idx] = 1;
      l1_drt[idx] = 0;
      l1_tag[idx] = tg;
    end
    if (is_wr) begin
      l1_data[idx*WPL + off] = word;
      l1_drt[idx] = 1;
      cost += cost_reg[REG_L1_WRITE];
    end else begin
      word = l1_data[idx*WPL + off];
      cost += cost_reg[REG_L1_READ];
    end
    return cost;
  endfunction

  function automatic access_result_t predict_access(step_t it);
    access_result_t r;
    logic [31:0] w = it.data;
    int cost = 0;
    r.rd = 0;
    r.oor = 0;
    if (it.op == OP_CLEAR) begin
      elapsed_acc = 0;
    end else if (it.op == OP_READ || it.op == OP_WRITE) begin
      if (it.addr > ADDR_LIMIT) begin
        r.oor = 1;
      end else begin
        cost = l1_access({it.addr[31:2], 2'b00}, it.op == OP_WRITE, w);
        if (it.op == OP_READ) r.rd = w;
        elapsed_acc += cost;
      end
    end
    r.cost = cost[11:0];
    r.elapsed = elapsed_acc;
    return r;
  endfunction

  function automatic step_t mk_item(logic [1:0] op, logic [31:0] addr, logic [31:0] data);
    step_t s;
    s.kind = K_ITEM;
    s.op = op;
    s.addr = addr;
    s.data = data;
    s.reg_idx = REG_L1_READ;
    s.reg_val = 0;
    s.send_pct = 0;
    s.recv_pct = 0;
    return s;
  endfunction

  function automatic step_t mk_cfg(logic [2:0] idx, logic [7:0] val);
    step_t s = mk_item(OP_NOP, 0, 0);
    s.kind = K_CFG;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic step_t mk_phase(int sp, int rp);
    step_t s = mk_item(OP_NOP, 0, 0);
    s.kind = K_PHASE;
    s.send_pct = sp;
    s.recv_pct = rp;
    return s;
  endfunction

  // Most addresses land in a few conflicting lines so hits, misses and dirty
  // victims at both levels all occur often.
  function automatic logic [31:0] pick_addr();
    int sel = $urandom_range(0, 99);
    if (sel < 65)
      return 32'($urandom_range(0, 7) * 16384 + $urandom_range(0, 3) * 64
                 + $urandom_range(0, 15) * 4 + $urandom_range(0, 3));
    else if (sel < 85) return 32'($urandom_range(0, 32'hFFFFF));
    else if (sel < 92) return 32'($urandom_range(32'hFFFF0, 32'hFFFFF));
    else return $urandom();
  endfunction

  function automatic logic [1:0] pick_op();
    int sel = $urandom_range(0, 99);
    if (sel < 45) return OP_READ;
    else if (sel < 90) return OP_WRITE;
    else if (sel < 95) return OP_CLEAR;
    else return OP_NOP;
  endfunction

  task automatic add_cfg_set(logic [7:0] v0, logic [7:0] v1, logic [7:0] v2,
                             logic [7:0] v3, logic [7:0] v4, logic [7:0] v5);
    stim_q.push_back(mk_cfg(REG_L1_READ, v0));
    stim_q.push_back(mk_cfg(REG_L1_WRITE, v1));
    stim_q.push_back(mk_cfg(REG_L2_READ, v2));
    stim_q.push_back(mk_cfg(REG_L2_WRITE, v3));
    stim_q.push_back(mk_cfg(REG_MEM_READ, v4));
    stim_q.push_back(mk_cfg(REG_MEM_WRITE, v5));
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) stim_q.push_back(mk_item(pick_op(), pick_addr(), $urandom()));
  endtask

  // Driver: presents queued transactions, applies register writes and phase changes once the core is quiet.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      cfg_write <= 0;
      quiet = 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        pending_results.push_back(predict_access(cur_item));
        items_sent++;
      end
      if (in_valid || pending_results.size() != 0 || out_valid) quiet = 0;
      else quiet++;
      nv = in_valid && !took;
      cw = 0;
      if (!nv && stim_q.size() > 0) begin
        head = stim_q[0];
        if (head.kind == K_ITEM) begin
          if ($urandom_range(0, 99) >= send_pct) begin
            void'(stim_q.pop_front());
            cur_item = head;
            nv = 1;
            opcode <= head.op;
            byte_address <= head.addr;
            write_data <= head.data;
          end
        end else if (!took && pending_results.size() == 0 && quiet >= QUIET_CYCLES) begin
          void'(stim_q.pop_front());
          if (head.kind == K_CFG) begin
            cw = 1;
            cfg_index <= head.reg_idx;
            cfg_data <= head.reg_val;
            cost_reg[head.reg_idx] = head.reg_val;
          end else begin
            send_pct = head.send_pct;
            recv_pct = head.recv_pct;
          end
        end
      end
      in_valid <= nv;
      cfg_write <= cw;
    end
  end

  // Receiver stall, including one long hold-off that fills the core.
  always @(posedge clk) begin
    if (!rst && !hold_done && send_pct == 7 && results_seen >= 250) begin
      hold_done = 1;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) hold_cnt--;
    out_stall <= (hold_cnt > 0) || ($urandom_range(0, 99) < recv_pct);
  end

  // Monitor.
  always @(posedge clk) begin
    access_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: rd=%h", read_data);
      end else begin
        want = pending_results.pop_front();
        if (read_data !== want.rd || access_cost !== want.cost
            || elapsed_time !== want.elapsed || out_of_range !== want.oor) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: rd %h/%h cost %0d/%0d elapsed %0d/%0d oor %b/%b",
                     results_seen, want.rd, read_data, want.cost, access_cost,
                     want.elapsed, elapsed_time, want.oor, out_of_range);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("** two_level_writeback_cache_core: FAILED **");
      $finish;
    end
  end

  initial begin
    cost_reg[0] = RST_L1_READ;
    cost_reg[1] = RST_L1_WRITE;
    cost_reg[2] = RST_L2_READ;
    cost_reg[3] = RST_L2_WRITE;
    cost_reg[4] = RST_MEM_READ;
    cost_reg[5] = RST_MEM_WRITE;
    for (int i = 0; i < L1_LINES; i++) begin
      l1_tag[i] = 0; l1_vld[i] = 0; l1_drt[i] = 0;
    end
    for (int i = 0; i < L2_LINES; i++) begin
      l2_tag[i] = 0; l2_vld[i] = 0; l2_drt[i] = 0;
    end
    for (int i = 0; i < L1_LINES*WPL; i++) l1_data[i] = 0;
    for (int i = 0; i < L2_LINES*WPL; i++) l2_data[i] = 0;
    elapsed_acc = 0;

    add_cfg_set(RST_L1_READ, RST_L1_WRITE, RST_L2_READ, RST_L2_WRITE,
                RST_MEM_READ, RST_MEM_WRITE);
    stim_q.push_back(mk_item(OP_READ, 32'h0, 32'h0));
    stim_q.push_back(mk_item(OP_WRITE, 32'h0, 32'hFFFF_FFFF));
    stim_q.push_back(mk_item(OP_READ, 32'h0, 32'h0));
    stim_q.push_back(mk_item(OP_WRITE, 32'h4000, 32'h1234_5678));  // dirty L1 victim
    stim_q.push_back(mk_item(OP_WRITE, 32'h8000, 32'h0));          // dirty L2 victim
    stim_q.push_back(mk_item(OP_WRITE, 32'h10000, 32'hA5A5_5A5A));  // L2 conflict
    stim_q.push_back(mk_item(OP_READ, 32'h0, 32'h0));
    stim_q.push_back(mk_item(OP_READ, 32'h4000, 32'h0));
    stim_q.push_back(mk_item(OP_WRITE, ADDR_LIMIT, 32'hDEAD_BEEF));
    stim_q.push_back(mk_item(OP_READ, ADDR_LIMIT, 32'h0));
    stim_q.push_back(mk_item(OP_READ, ADDR_LIMIT + 1, 32'h0));       // above ADDR_LIMIT
    stim_q.push_back(mk_item(OP_WRITE, 32'h000F_FFFF, 32'h1));
    stim_q.push_back(mk_item(OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    stim_q.push_back(mk_item(OP_READ, 32'h8000_0000, 32'h0));
    stim_q.push_back(mk_item(OP_WRITE, 32'h0000_0107, 32'h7777_0001)); // unaligned
    stim_q.push_back(mk_item(OP_READ, 32'h0000_0105, 32'h0));
    stim_q.push_back(mk_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    stim_q.push_back(mk_item(OP_READ, 32'h0000_0104, 32'h0));
    stim_q.push_back(mk_item(OP_NOP, 32'h0, 32'h0));
    stim_q.push_back(mk_item(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    stim_q.push_back(mk_item(OP_WRITE, 32'h000F_FFC0, 32'h0F0F_F0F0));

    stim_q.push_back(mk_phase(0, 0));
    add_cfg_set(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    stim_q.push_back(mk_phase(7, 58));
    add_random(RAND_ITEMS);
    stim_q.push_back(mk_phase(7, 58));   // sender waits for every result here
    add_cfg_set(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    stim_q.push_back(mk_phase(58, 7));
    add_random(RAND_ITEMS);
    stim_q.push_back(mk_phase(58, 7));
    add_cfg_set(8'($urandom()), 8'($urandom()), 8'($urandom()),
                8'($urandom()), 8'($urandom()), 8'($urandom()));
    stim_q.push_back(mk_phase(0, 0));
    add_random(RAND_ITEMS);

    repeat (9) @(posedge clk);
    rst <= 0;
    wait (stim_q.size() == 0 && !in_valid && pending_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d transactions (%0d results) over four cost settings,",
             items_sent, results_seen);
    $display("with hits, fills, dirty victims at both levels, clears and out-of-range.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** two_level_writeback_cache_core: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("** two_level_writeback_cache_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
